FILE: rtl/mbgc_pkg.sv
// ----------------------------------------------------------------------------
// mbgc_pkg
// Types, constants and codes shared by the magnetometer bias/gain calibration
// core.
// ----------------------------------------------------------------------------
package mbgc_pkg;

	localparam int SAMPLES_PER_BIAS = 10;

	localparam int SAMPLE_W  = 16;
	localparam int SUM_W     = 24;
	localparam int GAIN_W    = 24;
	localparam int REF_W     = 10;
	localparam int CPG_W     = 12;
	localparam int PROD1_W   = CPG_W + REF_W;
	localparam int NUM_SCALE = 2 * SAMPLES_PER_BIAS * 256;
	localparam int NUM_W     = PROD1_W + $clog2(NUM_SCALE + 1);
	localparam int HI_W      = NUM_W - GAIN_W;
	localparam int MPROD_W   = SAMPLE_W + GAIN_W + 1;
	localparam int DIV_CNT_W = $clog2(GAIN_W);

	localparam logic [GAIN_W-1:0]    GAIN_MAX  = '1;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(GAIN_W - 1);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_REF_X    = 3'd0;
	localparam logic [2:0] REG_REF_Y    = 3'd1;
	localparam logic [2:0] REG_REF_Z    = 3'd2;
	localparam logic [2:0] REG_CPG      = 3'd3;
	localparam logic [2:0] REG_OFFSET_X = 3'd4;
	localparam logic [2:0] REG_OFFSET_Y = 3'd5;
	localparam logic [2:0] REG_OFFSET_Z = 3'd6;

	localparam logic [REF_W-1:0]    RST_REF_X    = 10'd297;
	localparam logic [REF_W-1:0]    RST_REF_Y    = 10'd297;
	localparam logic [REF_W-1:0]    RST_REF_Z    = 10'd276;
	localparam logic [CPG_W-1:0]    RST_CPG      = 12'd820;
	localparam logic [SAMPLE_W-1:0] RST_OFFSET_X = 16'hFF31;
	localparam logic [SAMPLE_W-1:0] RST_OFFSET_Y = 16'hFFF4;
	localparam logic [SAMPLE_W-1:0] RST_OFFSET_Z = 16'hFF2F;

	localparam logic [1:0] ACT_POS  = 2'd0;
	localparam logic [1:0] ACT_NEG  = 2'd1;
	localparam logic [1:0] ACT_FIN  = 2'd2;
	localparam logic [1:0] ACT_MEAS = 2'd3;

	localparam logic [1:0] ST_MEAS = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_CAL  = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [1:0]                  action;
		logic signed [SAMPLE_W-1:0]  sample_x;
		logic signed [SAMPLE_W-1:0]  sample_y;
		logic signed [SAMPLE_W-1:0]  sample_z;
	} in_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic signed [SAMPLE_W-1:0]  axis_first;
		logic signed [SAMPLE_W-1:0]  axis_second;
		logic signed [SAMPLE_W-1:0]  axis_third;
	} out_t;

	typedef struct packed {
		logic [REF_W-1:0]            ref_x;
		logic [REF_W-1:0]            ref_y;
		logic [REF_W-1:0]            ref_z;
		logic [CPG_W-1:0]            counts_per_gauss;
		logic signed [SAMPLE_W-1:0]  offset_x;
		logic signed [SAMPLE_W-1:0]  offset_y;
		logic signed [SAMPLE_W-1:0]  offset_z;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       acc;
		logic       num;
		logic       scale;
		logic       div_init;
		logic       div_step;
		logic       gain_wr;
		logic       clr_sum;
		logic       mul;
		logic       cor;
		logic       publish;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       div_last;
	} sts_t;

endpackage

FILE: rtl/mbgc_regs.sv
// ----------------------------------------------------------------------------
// mbgc_regs
// APB-style configuration registers: reference fields, counts per gauss and
// per-axis offsets.
// ----------------------------------------------------------------------------
module mbgc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbgc_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbgc_pkg::DATA_W-1:0]  pwdata,
	output logic [mbgc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output mbgc_pkg::cfg_t               cfg
);
	import mbgc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_x            <= RST_REF_X;
			cfg_q.ref_y            <= RST_REF_Y;
			cfg_q.ref_z            <= RST_REF_Z;
			cfg_q.counts_per_gauss <= RST_CPG;
			cfg_q.offset_x         <= RST_OFFSET_X;
			cfg_q.offset_y         <= RST_OFFSET_Y;
			cfg_q.offset_z         <= RST_OFFSET_Z;
		end else if (wr_en) begin
			case (idx)
				REG_REF_X:    cfg_q.ref_x            <= pwdata[REF_W-1:0];
				REG_REF_Y:    cfg_q.ref_y            <= pwdata[REF_W-1:0];
				REG_REF_Z:    cfg_q.ref_z            <= pwdata[REF_W-1:0];
				REG_CPG:      cfg_q.counts_per_gauss <= pwdata[CPG_W-1:0];
				REG_OFFSET_X: cfg_q.offset_x         <= pwdata[SAMPLE_W-1:0];
				REG_OFFSET_Y: cfg_q.offset_y         <= pwdata[SAMPLE_W-1:0];
				REG_OFFSET_Z: cfg_q.offset_z         <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_REF_X:    prdata = DATA_W'(cfg_q.ref_x);
			REG_REF_Y:    prdata = DATA_W'(cfg_q.ref_y);
			REG_REF_Z:    prdata = DATA_W'(cfg_q.ref_z);
			REG_CPG:      prdata = DATA_W'(cfg_q.counts_per_gauss);
			REG_OFFSET_X: prdata = DATA_W'(cfg_q.offset_x);
			REG_OFFSET_Y: prdata = DATA_W'(cfg_q.offset_y);
			REG_OFFSET_Z: prdata = DATA_W'(cfg_q.offset_z);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: rtl/mbgc_dp.sv
// ----------------------------------------------------------------------------
// mbgc_dp
// Datapath: bias sums, gains, numerator multiplier, serial restoring divider,
// measurement multiplier with offset correction, and the output register.
// ----------------------------------------------------------------------------
module mbgc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  mbgc_pkg::in_t    in_data,
	input  mbgc_pkg::cfg_t   cfg,
	input  mbgc_pkg::cmd_t   cmd,
	output mbgc_pkg::sts_t   sts,
	output mbgc_pkg::out_t   out_data
);
	import mbgc_pkg::*;

	in_t                       in_q;
	logic signed [SUM_W-1:0]   sum_q [3];
	logic [GAIN_W-1:0]         gain_q [3];
	logic signed [SAMPLE_W-1:0] res_q [3];
	logic [PROD1_W-1:0]        prod1_q;
	logic [NUM_W-1:0]          num_q;
	logic [GAIN_W-1:0]         mag_q;
	logic [GAIN_W-1:0]         rem_q;
	logic [GAIN_W-1:0]         quo_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic                      sat_q;
	logic                      zero_q;
	logic signed [MPROD_W-1:0] prod_q;
	out_t                      out_q;

	logic signed [SUM_W-1:0]    sum_next [3];
	logic signed [SAMPLE_W-1:0] samp_lane [3];
	logic signed [SUM_W:0]      acc_t [3];
	logic signed [SUM_W-1:0]    sum_sel;
	logic [REF_W-1:0]           ref_sel;
	logic signed [SAMPLE_W-1:0] samp_sel;
	logic [GAIN_W-1:0]          gain_sel;
	logic signed [SAMPLE_W-1:0] off_sel;
	logic [GAIN_W-1:0]          mag_next;
	logic [GAIN_W-1:0]          num_hi;
	logic [GAIN_W:0]            div_t;
	logic                       div_ge;
	logic [MPROD_W-17:0]        q_trunc;
	logic signed [MPROD_W-15:0] d_cor;
	logic signed [SAMPLE_W-1:0] cor_val;
	logic [1:0]                 res_status;

	assign samp_lane[0] = in_q.sample_x;
	assign samp_lane[1] = in_q.sample_y;
	assign samp_lane[2] = in_q.sample_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (in_q.action == ACT_POS)
				acc_t[i] = (SUM_W+1)'(sum_q[i]) + (SUM_W+1)'(samp_lane[i]);
			else
				acc_t[i] = (SUM_W+1)'(sum_q[i]) - (SUM_W+1)'(samp_lane[i]);
			if (acc_t[i] > (SUM_W+1)'(signed'({2'b00, {(SUM_W-1){1'b1}}})))
				sum_next[i] = {1'b0, {(SUM_W-1){1'b1}}};
			else if (acc_t[i] < (SUM_W+1)'(signed'({2'b11, {(SUM_W-1){1'b0}}})))
				sum_next[i] = {1'b1, {(SUM_W-1){1'b0}}};
			else
				sum_next[i] = acc_t[i][SUM_W-1:0];
		end
	end

	always_comb begin
		case (cmd.axis)
			AXIS_Y: begin
				sum_sel  = sum_q[1];
				ref_sel  = cfg.ref_y;
				samp_sel = in_q.sample_y;
				gain_sel = gain_q[1];
				off_sel  = cfg.offset_y;
			end
			AXIS_Z: begin
				sum_sel  = sum_q[2];
				ref_sel  = cfg.ref_z;
				samp_sel = in_q.sample_z;
				gain_sel = gain_q[2];
				off_sel  = cfg.offset_z;
			end
			default: begin
				sum_sel  = sum_q[0];
				ref_sel  = cfg.ref_x;
				samp_sel = in_q.sample_x;
				gain_sel = gain_q[0];
				off_sel  = cfg.offset_x;
			end
		endcase
	end

	assign mag_next = sum_sel[SUM_W-1] ? GAIN_W'(-sum_sel) : GAIN_W'(sum_sel);
	assign num_hi   = GAIN_W'(num_q[NUM_W-1:GAIN_W]);
	assign div_t    = {rem_q, quo_q[GAIN_W-1]};
	assign div_ge   = div_t >= {1'b0, mag_q};

	assign q_trunc = prod_q[MPROD_W-1:16]
		+ (MPROD_W-16)'(prod_q[MPROD_W-1] && (prod_q[15:0] != 16'd0));
	assign d_cor   = signed'({q_trunc[MPROD_W-17], q_trunc})
		- signed'((MPROD_W-14)'(off_sel));

	always_comb begin
		if (d_cor > (MPROD_W-14)'(signed'(17'sd32767)))
			cor_val = 16'sh7FFF;
		else if (d_cor < (MPROD_W-14)'(signed'(-17'sd32768)))
			cor_val = 16'sh8000;
		else
			cor_val = d_cor[SAMPLE_W-1:0];
	end

	always_comb begin
		case (in_q.action)
			ACT_POS, ACT_NEG: res_status = ST_ACC;
			ACT_FIN:          res_status = zero_q ? ST_ERR : ST_CAL;
			ACT_MEAS:         res_status = ST_MEAS;
			default:          res_status = ST_MEAS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i]  <= '0;
				gain_q[i] <= '0;
			end
			div_cnt_q <= '0;
		end else begin
			if (cmd.clr_sum) begin
				for (int i = 0; i < 3; i++)
					sum_q[i] <= '0;
			end else if (cmd.acc) begin
				for (int i = 0; i < 3; i++)
					sum_q[i] <= sum_next[i];
			end
			if (cmd.gain_wr) begin
				case (cmd.axis)
					AXIS_Y:  gain_q[1] <= sat_q ? GAIN_MAX : quo_q;
					AXIS_Z:  gain_q[2] <= sat_q ? GAIN_MAX : quo_q;
					default: gain_q[0] <= sat_q ? GAIN_MAX : quo_q;
				endcase
			end
			if (cmd.div_init)
				div_cnt_q <= DIV_LAST;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q   <= in_data;
			zero_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				res_q[i] <= '0;
		end
		if (cmd.num)
			prod1_q <= cfg.counts_per_gauss * ref_sel;
		if (cmd.scale) begin
			num_q <= NUM_W'(prod1_q) * NUM_W'(NUM_SCALE);
			mag_q <= mag_next;
		end
		if (cmd.div_init) begin
			rem_q <= num_hi;
			quo_q <= num_q[GAIN_W-1:0];
			sat_q <= (mag_q == '0) || (num_hi >= mag_q);
			if (mag_q == '0)
				zero_q <= 1'b1;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? GAIN_W'(div_t - {1'b0, mag_q}) : div_t[GAIN_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], div_ge};
		end
		if (cmd.mul)
			prod_q <= samp_sel * signed'({1'b0, gain_sel});
		if (cmd.cor) begin
			case (cmd.axis)
				AXIS_Y:  res_q[1] <= cor_val;
				AXIS_Z:  res_q[2] <= cor_val;
				default: res_q[0] <= cor_val;
			endcase
		end
		if (cmd.publish) begin
			out_q.status      <= res_status;
			out_q.axis_first  <= res_q[0];
			out_q.axis_second <= res_q[2];
			out_q.axis_third  <= res_q[1];
		end
	end

	assign sts.action   = in_q.action;
	assign sts.div_last = (div_cnt_q == '0);
	assign out_data     = out_q;

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sat_q) |-> (rem_q < mag_q))
		else $error("divider remainder reached divisor");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_sum |=> (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0))
		else $error("bias sums not cleared after finish");

	a_zero_sum_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_init && mag_q == '0) |=> (zero_q && sat_q))
		else $error("zero sum not flagged");

endmodule

FILE: rtl/mbgc_ctrl.sv
// ----------------------------------------------------------------------------
// mbgc_ctrl
// Controller: input and output handshakes and the sequence of datapath
// commands for accumulate, finish and measure transactions.
// ----------------------------------------------------------------------------
module mbgc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  mbgc_pkg::sts_t   sts,
	output mbgc_pkg::cmd_t   cmd
);
	import mbgc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_ACC   = 4'd2;
	localparam logic [3:0] S_NUM   = 4'd3;
	localparam logic [3:0] S_SCALE = 4'd4;
	localparam logic [3:0] S_DINIT = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_GAIN  = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_COR   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		state_d  = state_q;
		axis_d   = axis_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				axis_d = AXIS_X;
				case (sts.action)
					ACT_POS, ACT_NEG: state_d = S_ACC;
					ACT_FIN:          state_d = S_NUM;
					default:          state_d = S_MUL;
				endcase
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_FIN;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_GAIN;
			end
			S_GAIN: begin
				cmd.gain_wr = 1'b1;
				if (axis_q == AXIS_Z) begin
					cmd.clr_sum = 1'b1;
					state_d     = S_FIN;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_NUM;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_COR;
			end
			S_COR: begin
				cmd.cor = 1'b1;
				if (axis_q == AXIS_Z) begin
					state_d = S_FIN;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISP))
		else $error("accepted transaction not dispatched");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !sts.div_last) |=> (state_q == S_DIV))
		else $error("divider left before last step");

	a_last_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAIN && axis_q == AXIS_Z) |=> (state_q == S_FIN))
		else $error("finish did not complete after last axis");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> out_free)
		else $error("result overwritten before it was taken");

endmodule

FILE: rtl/magnetometer_bias_gain_calibrate_core.sv
// ----------------------------------------------------------------------------
// magnetometer_bias_gain_calibrate_core
// Self-test bias/gain calibration and measurement correction for a three-axis
// magnetometer. One transaction in gives one result out. Bias-sample
// transactions accumulate the samples into the bias sums, measurements make
// one shared multiply and correct pass per axis, and a finish transaction
// forms each of the three gains with a 24-step restoring divider that
// produces one quotient bit per cycle, after numerator setup and before a
// gain write-back per axis. A new transaction is taken only after the
// previous one has been worked through; a finished result waits in the output
// register without holding up the input.
// ----------------------------------------------------------------------------
module magnetometer_bias_gain_calibrate_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mbgc_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mbgc_pkg::out_t               out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbgc_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbgc_pkg::DATA_W-1:0]  pwdata,
	output logic [mbgc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import mbgc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	mbgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbgc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
